/* sv/kpfp_pkg.sv */
// Package for the kinematic profile unit: constants, state and job codes,
// and the CORDIC arctangent table. No dependencies.
package kpfp_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Reset values of the configuration registers.
    localparam logic [30:0] RST_STEP_TIME  = 31'd6554;
    localparam logic [30:0] RST_MAX_SPEED  = 31'd655360;
    localparam logic [30:0] RST_STEER_LIM  = 31'd45875;
    localparam logic [30:0] RST_WHEEL_BASE = 31'd183501;
    localparam logic [31:0] RST_ACCEL_MIN  = 32'hFFFD_0000;
    localparam logic [30:0] RST_ACCEL_MAX  = 31'd131072;
    localparam logic [30:0] RST_RATE_LIM   = 31'd32768;
    localparam logic [30:0] RST_JERK_LIM   = 31'd196608;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_STEP_TIME  = 3'd0;
    localparam logic [2:0] REG_MAX_SPEED  = 3'd1;
    localparam logic [2:0] REG_STEER_LIM  = 3'd2;
    localparam logic [2:0] REG_WHEEL_BASE = 3'd3;
    localparam logic [2:0] REG_ACCEL_MIN  = 3'd4;
    localparam logic [2:0] REG_ACCEL_MAX  = 3'd5;
    localparam logic [2:0] REG_RATE_LIM   = 3'd6;
    localparam logic [2:0] REG_JERK_LIM   = 3'd7;

    // pi/2 in Q.32 radians.
    localparam logic [63:0] HALF_PI_Q32 = 64'd6746518852;

    // Multiplier passes, square root passes, CORDIC passes, angle width.
    localparam int MUL_N    = 33;
    localparam int SQ_N     = 33;
    localparam int CORDIC_N = 32;
    localparam int ZW       = 35;

    typedef enum logic [14:0] {
        S_IDLE  = 15'h0001,
        S_DIFF  = 15'h0002,
        S_ABS   = 15'h0004,
        S_MUL   = 15'h0008,
        S_MDONE = 15'h0010,
        S_SQRT  = 15'h0020,
        S_ROOT  = 15'h0040,
        S_DIV   = 15'h0080,
        S_DDONE = 15'h0100,
        S_NORM  = 15'h0200,
        S_CORD  = 15'h0400,
        S_ROUND = 15'h0800,
        S_PHI   = 15'h1000,
        S_RATE  = 15'h2000,
        S_OUT   = 15'h4000
    } t_state;

    typedef enum logic [2:0] {
        J_DX, J_DY, J_SPD, J_HEAD, J_DEN, J_ACC, J_OMG, J_JRK
    } t_job;

    typedef enum logic [1:0] {
        CP_X, CP_Y, CP_Z
    } t_cphase;

    // atan(2^-i) in Q.32 radians.
    function automatic logic [31:0] f_atan(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'd3373259426;
            5'd1:  v = 32'd1991351318;
            5'd2:  v = 32'd1052175346;
            5'd3:  v = 32'd534100635;
            5'd4:  v = 32'd268086748;
            5'd5:  v = 32'd134174063;
            5'd6:  v = 32'd67103403;
            5'd7:  v = 32'd33553749;
            5'd8:  v = 32'd16777131;
            5'd9:  v = 32'd8388597;
            5'd10: v = 32'd4194303;
            5'd11: v = 32'd2097152;
            5'd12: v = 32'd1048576;
            5'd13: v = 32'd524288;
            5'd14: v = 32'd262144;
            5'd15: v = 32'd131072;
            5'd16: v = 32'd65536;
            5'd17: v = 32'd32768;
            5'd18: v = 32'd16384;
            5'd19: v = 32'd8192;
            5'd20: v = 32'd4096;
            5'd21: v = 32'd2048;
            5'd22: v = 32'd1024;
            5'd23: v = 32'd512;
            5'd24: v = 32'd256;
            5'd25: v = 32'd128;
            5'd26: v = 32'd64;
            5'd27: v = 32'd32;
            5'd28: v = 32'd16;
            5'd29: v = 32'd8;
            5'd30: v = 32'd4;
            default: v = 32'd2;
        endcase
        return v;
    endfunction

endpackage

/* sv/kinematic_profile_from_path_unit.sv */
// Kinematic profile unit: speed, steering angle and their rates from path points.
// Depends on kpfp_pkg.
//
// Usage:
// Input channel (i_valid / o_stall) carries one path point: x, y, heading and a
// first-point flag. A transfer happens when i_valid is high and o_stall is low.
// Output channel (o_valid / i_stall) carries one result per point: speed,
// steering angle, acceleration, steering rate and jerk.
// The APB port writes and reads the eight configuration registers at byte
// addresses 0, 4, ... 28; write them only while the unit is idle.
// A first point produces its all-zero result in the cycle after its transfer.
// Any other point runs through one shared adder under the sequencer: four
// shift-add multiplies, a square root, four restoring divisions, a normalization
// and a CORDIC (three adder passes per rotation) before the output transfer.
// A zero step time skips the divisions, and degenerate angles skip the
// normalization and the CORDIC.
// The next point can be taken in the cycle after the output transfer.
// The result is held on the outputs until the receiver takes it; the input
// stays stalled until then. Reset restores the register defaults and clears
// the stored previous point and derivatives.
module kinematic_profile_from_path_unit #(
    parameter int FRAC_BITS = kpfp_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_heading,
    input  logic               i_first_point,
    output logic               o_valid,
    input  logic               i_stall,
    output logic        [30:0] o_speed,
    output logic signed [31:0] o_steer_angle,
    output logic signed [31:0] o_accel,
    output logic signed [31:0] o_steer_rate,
    output logic signed [31:0] o_jerk_value,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [4:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);
    import kpfp_pkg::*;

    localparam int DN   = 33 + FRAC_BITS;
    localparam int AW   = (DN + 3 > 68) ? DN + 3 : 68;
    localparam int CW   = DN + 2;
    localparam int SH   = 32 - FRAC_BITS;
    localparam int CNTW = $clog2(DN);
    localparam int RADW = 2 * MUL_N;
    localparam logic [63:0] HALF_PI_QF = (HALF_PI_Q32 + (64'd1 << (SH - 1))) >> SH;
    localparam logic [AW-1:0] RND_BIT = AW'(64'd1 << (SH - 1));

    function automatic logic signed [CW-1:0] f_clamp(input logic signed [CW-1:0] q,
                                                     input logic signed [CW-1:0] lo,
                                                     input logic signed [CW-1:0] hi);
        logic signed [CW-1:0] t;
        t = (lo < q) ? q : lo;
        return (t < hi) ? t : hi;
    endfunction

    // Configuration.
    logic        [30:0] r_step_time, r_max_speed, r_steer_limit, r_wheel_base;
    logic signed [31:0] r_accel_min;
    logic        [30:0] r_accel_max, r_rate_limit, r_jerk_limit;

    // Control and stored path state.
    t_state             r_state, n_state;
    t_job               r_job, n_job;
    logic signed [31:0] r_last_x, r_last_y, r_last_h, r_last_steer, r_last_accel;
    logic        [30:0] r_last_speed;

    // Datapath.
    logic signed [31:0] r_px, r_py, r_ph;
    logic        [AW-1:0] r_a, r_b, r_c, r_t, r_sq;
    logic        [DN-1:0] r_m;
    logic        [63:0] r_num;
    logic        [32:0] r_q;
    logic        [31:0] r_qs;
    logic               r_qneg, r_neg, r_zero, r_dir;
    logic signed [ZW-1:0] r_z;
    logic        [CNTW-1:0] r_cnt;
    t_cphase            r_phase;
    logic        [30:0] r_v;
    logic signed [31:0] r_phi, r_acc, r_omega, r_jerk;

    // Shared adder.
    logic [AW-1:0] w_opa, w_opb, w_sum;
    logic          w_sub, w_neg;

    logic          w_cfg_wr, w_step_zero, w_shr, w_shl, w_den_zero, w_num_zero, w_mul_job;
    logic [AW-1:0] w_da, w_db, w_rem2_sq, w_rem2_div;
    logic [63:0]   w_ys, w_or;
    logic [ZW-1:0] w_zc;
    logic signed [CW-1:0] w_lo, w_hi, w_q, w_phi_q, w_rate;

    assign w_cfg_wr    = psel & penable & pwrite & pready;
    assign pready      = 1'b1;
    assign w_step_zero = (r_step_time == '0);
    assign w_den_zero  = (r_a[63:0] == '0);
    assign w_num_zero  = (r_num == '0);
    assign w_mul_job   = (r_job == J_DX) || (r_job == J_DY) || (r_job == J_HEAD);
    assign w_or        = r_b[63:0] | r_c[63:0];
    assign w_shr       = |w_or[63:59];
    assign w_shl       = ~|w_or[63:58];
    assign w_ys        = $signed(r_c[63:0]) >>> r_cnt[4:0];
    assign w_zc        = r_z[ZW-1] ? '0 : r_z;
    assign w_rem2_sq   = {r_a[AW-3:0], r_c[RADW-1 -: 2]};
    assign w_rem2_div  = AW'({r_a[30:0], r_m[DN-1]});

    always_comb begin
        unique case (r_job)
            J_DX:    begin w_da = AW'(r_px);  w_db = AW'(r_last_x); end
            J_DY:    begin w_da = AW'(r_py);  w_db = AW'(r_last_y); end
            J_HEAD:  begin w_da = AW'(r_ph);  w_db = AW'(r_last_h); end
            J_ACC:   begin w_da = AW'(r_v);   w_db = AW'(r_last_speed); end
            J_OMG:   begin w_da = AW'(r_phi); w_db = AW'(r_last_steer); end
            J_JRK:   begin w_da = AW'(r_acc); w_db = AW'(r_last_accel); end
            default: begin w_da = '0;         w_db = '0; end
        endcase
    end

    always_comb begin
        w_opa = '0;
        w_opb = '0;
        w_sub = 1'b0;
        unique case (r_state)
            S_DIFF: begin w_opa = w_da; w_opb = w_db; w_sub = 1'b1; end
            S_ABS:  begin w_opb = r_t; w_sub = r_t[AW-1]; end
            S_MUL:  begin w_opa = r_a; w_opb = r_m[0] ? r_b : '0; end
            S_MDONE: begin w_opa = r_sq; w_opb = r_a; end
            S_SQRT: begin
                w_opa = w_rem2_sq;
                w_opb = AW'({r_q, 2'b01});
                w_sub = 1'b1;
            end
            S_DIV:  begin w_opa = w_rem2_div; w_opb = AW'(r_step_time); w_sub = 1'b1; end
            S_CORD: begin
                unique case (r_phase)
                    CP_X: begin
                        w_opa = AW'(r_b[63:0]);
                        w_opb = AW'(w_ys);
                        w_sub = r_c[63];
                    end
                    CP_Y: begin
                        w_opa = AW'(r_c[63:0]);
                        w_opb = AW'(r_b[63:0] >> r_cnt[4:0]);
                        w_sub = ~r_dir;
                    end
                    default: begin
                        w_opa = AW'(r_z);
                        w_opb = AW'(f_atan(r_cnt[4:0]));
                        w_sub = r_dir;
                    end
                endcase
            end
            S_ROUND: begin w_opa = AW'(w_zc); w_opb = RND_BIT; end
            S_PHI:   begin w_opb = AW'(r_qs); w_sub = r_qneg; end
            S_RATE:  begin
                w_opb = w_step_zero ? AW'({DN{1'b1}}) : AW'(r_m);
                w_sub = r_neg;
            end
            default: ;
        endcase
    end

    assign w_sum = w_opa + (w_opb ^ {AW{w_sub}}) + AW'(w_sub);
    assign w_neg = w_sum[AW-1];

    // Clamp bounds of the rate being finished.
    always_comb begin
        unique case (r_job)
            J_ACC: begin
                w_lo = CW'(r_accel_min);
                w_hi = CW'({1'b0, r_accel_max});
            end
            J_OMG: begin
                w_hi = CW'({1'b0, r_rate_limit});
                w_lo = -w_hi;
            end
            default: begin
                w_hi = CW'({1'b0, r_jerk_limit});
                w_lo = -w_hi;
            end
        endcase
    end

    assign w_q     = (w_step_zero && r_zero) ? w_lo : $signed(w_sum[CW-1:0]);
    assign w_rate  = f_clamp(w_q, w_lo, w_hi);
    assign w_phi_q = f_clamp($signed(w_sum[CW-1:0]), -CW'({1'b0, r_steer_limit}),
                             CW'({1'b0, r_steer_limit}));

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = i_first_point ? S_OUT : S_DIFF;
                    n_job   = J_DX;
                end
            end
            S_DIFF: n_state = S_ABS;
            S_ABS: begin
                priority if (w_mul_job) n_state = S_MUL;
                else if (w_step_zero)   n_state = S_RATE;
                else                    n_state = S_DIV;
            end
            S_MUL: if (r_cnt == '0) n_state = S_MDONE;
            S_MDONE: begin
                unique case (r_job)
                    J_DX:   begin n_state = S_DIFF; n_job = J_DY; end
                    J_DY:   n_state = S_SQRT;
                    J_HEAD: begin n_state = S_MUL; n_job = J_DEN; end
                    default: n_state = (w_den_zero || w_num_zero) ? S_PHI : S_NORM;
                endcase
            end
            S_SQRT: if (r_cnt == '0) n_state = S_ROOT;
            S_ROOT: begin
                if (w_step_zero) begin
                    n_state = S_DIFF;
                    n_job   = J_HEAD;
                end else begin
                    n_state = S_DIV;
                    n_job   = J_SPD;
                end
            end
            S_DIV: if (r_cnt == '0) n_state = S_DDONE;
            S_DDONE: begin
                if (r_job == J_SPD) begin
                    n_state = S_DIFF;
                    n_job   = J_HEAD;
                end else begin
                    n_state = S_RATE;
                end
            end
            S_NORM: if (!w_shr && !w_shl) n_state = S_CORD;
            S_CORD: begin
                if (r_phase == CP_Z && r_cnt[4:0] == 5'(CORDIC_N - 1)) n_state = S_ROUND;
            end
            S_ROUND: n_state = S_PHI;
            S_PHI: begin
                n_state = S_DIFF;
                n_job   = J_ACC;
            end
            S_RATE: begin
                unique case (r_job)
                    J_ACC:   begin n_state = S_DIFF; n_job = J_OMG; end
                    J_OMG:   begin n_state = S_DIFF; n_job = J_JRK; end
                    default: n_state = S_OUT;
                endcase
            end
            S_OUT: if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_job         <= J_DX;
            r_step_time   <= RST_STEP_TIME;
            r_max_speed   <= RST_MAX_SPEED;
            r_steer_limit <= RST_STEER_LIM;
            r_wheel_base  <= RST_WHEEL_BASE;
            r_accel_min   <= RST_ACCEL_MIN;
            r_accel_max   <= RST_ACCEL_MAX;
            r_rate_limit  <= RST_RATE_LIM;
            r_jerk_limit  <= RST_JERK_LIM;
            r_last_x      <= '0;
            r_last_y      <= '0;
            r_last_h      <= '0;
            r_last_speed  <= '0;
            r_last_steer  <= '0;
            r_last_accel  <= '0;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
            if (w_cfg_wr) begin
                unique case (paddr[4:2])
                    REG_STEP_TIME:  r_step_time   <= pwdata[30:0];
                    REG_MAX_SPEED:  r_max_speed   <= pwdata[30:0];
                    REG_STEER_LIM:  r_steer_limit <= pwdata[30:0];
                    REG_WHEEL_BASE: r_wheel_base  <= pwdata[30:0];
                    REG_ACCEL_MIN:  r_accel_min   <= pwdata;
                    REG_ACCEL_MAX:  r_accel_max   <= pwdata[30:0];
                    REG_RATE_LIM:   r_rate_limit  <= pwdata[30:0];
                    default:        r_jerk_limit  <= pwdata[30:0];
                endcase
            end
            if (r_state == S_IDLE && i_valid && i_first_point) begin
                r_last_x     <= i_pos_x;
                r_last_y     <= i_pos_y;
                r_last_h     <= i_heading;
                r_last_speed <= '0;
                r_last_steer <= '0;
                r_last_accel <= '0;
            end else if (r_state == S_RATE && r_job == J_JRK) begin
                r_last_x     <= r_px;
                r_last_y     <= r_py;
                r_last_h     <= r_ph;
                r_last_speed <= r_v;
                r_last_steer <= r_phi;
                r_last_accel <= r_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_px <= i_pos_x;
                    r_py <= i_pos_y;
                    r_ph <= i_heading;
                    if (i_first_point) begin
                        r_v     <= '0;
                        r_phi   <= '0;
                        r_acc   <= '0;
                        r_omega <= '0;
                        r_jerk  <= '0;
                    end
                end
            end
            S_DIFF: r_t <= w_sum;
            S_ABS: begin
                r_neg  <= r_t[AW-1];
                r_zero <= (r_t == '0);
                r_a    <= '0;
                if (w_mul_job) begin
                    r_b   <= AW'(w_sum[32:0]);
                    r_m   <= (r_job == J_HEAD) ? DN'(r_wheel_base) : DN'(w_sum[32:0]);
                    r_cnt <= CNTW'(MUL_N - 1);
                end else begin
                    r_m   <= {w_sum[32:0], {FRAC_BITS{1'b0}}};
                    r_cnt <= CNTW'(DN - 1);
                end
            end
            S_MUL: begin
                r_a   <= w_sum;
                r_b   <= {r_b[AW-2:0], 1'b0};
                r_m   <= {1'b0, r_m[DN-1:1]};
                r_cnt <= r_cnt - 1'b1;
            end
            S_MDONE: begin
                unique case (r_job)
                    J_DX: r_sq <= r_a;
                    J_DY: begin
                        // Radicand dx*dx + dy*dy goes to the square root.
                        r_c   <= w_sum;
                        r_a   <= '0;
                        r_q   <= '0;
                        r_cnt <= CNTW'(SQ_N - 1);
                    end
                    J_HEAD: begin
                        r_num <= r_a[63:0];
                        r_a   <= '0;
                        r_b   <= AW'(r_v);
                        r_m   <= DN'(r_step_time);
                        r_cnt <= CNTW'(MUL_N - 1);
                    end
                    default: begin
                        // Degenerate angles skip the CORDIC.
                        priority if (w_den_zero && !w_num_zero) begin
                            r_qs   <= HALF_PI_QF[31:0];
                            r_qneg <= r_neg;
                        end else if (w_den_zero) begin
                            r_qs   <= {1'b0, r_steer_limit};
                            r_qneg <= 1'b1;
                        end else if (w_num_zero) begin
                            r_qs   <= '0;
                            r_qneg <= 1'b0;
                        end else begin
                            r_b    <= AW'(r_a[63:0]);
                            r_c    <= AW'(r_num);
                            r_qneg <= r_neg;
                        end
                    end
                endcase
            end
            S_SQRT: begin
                r_a   <= w_neg ? w_rem2_sq : w_sum;
                r_q   <= {r_q[31:0], ~w_neg};
                r_c   <= {r_c[AW-3:0], 2'b00};
                r_cnt <= r_cnt - 1'b1;
            end
            S_ROOT: begin
                if (w_step_zero) begin
                    r_v <= r_max_speed;
                end else begin
                    r_a   <= '0;
                    r_m   <= {r_q, {FRAC_BITS{1'b0}}};
                    r_cnt <= CNTW'(DN - 1);
                end
            end
            S_DIV: begin
                r_a   <= w_neg ? w_rem2_div : w_sum;
                r_m   <= {r_m[DN-2:0], ~w_neg};
                r_cnt <= r_cnt - 1'b1;
            end
            S_DDONE: begin
                if (r_job == J_SPD) begin
                    r_v <= (r_m < DN'(r_max_speed)) ? r_m[30:0] : r_max_speed;
                end
            end
            S_NORM: begin
                // Bring the larger operand into [2^58, 2^59).
                priority if (w_shr) begin
                    r_b <= AW'(r_b[63:1]);
                    r_c <= AW'(r_c[63:1]);
                end else if (w_shl) begin
                    r_b <= AW'({r_b[62:0], 1'b0});
                    r_c <= AW'({r_c[62:0], 1'b0});
                end else begin
                    r_cnt   <= '0;
                    r_phase <= CP_X;
                    r_z     <= '0;
                end
            end
            S_CORD: begin
                unique case (r_phase)
                    CP_X: begin
                        r_t     <= AW'(w_sum[63:0]);
                        r_dir   <= r_c[63];
                        r_phase <= CP_Y;
                    end
                    CP_Y: begin
                        r_c     <= AW'(w_sum[63:0]);
                        r_phase <= CP_Z;
                    end
                    default: begin
                        r_b     <= r_t;
                        r_z     <= w_sum[ZW-1:0];
                        r_cnt   <= r_cnt + 1'b1;
                        r_phase <= CP_X;
                    end
                endcase
            end
            S_ROUND: r_qs <= w_sum[SH +: 32];
            S_PHI:   r_phi <= w_phi_q[31:0];
            S_RATE: begin
                unique case (r_job)
                    J_ACC:   r_acc   <= w_rate[31:0];
                    J_OMG:   r_omega <= w_rate[31:0];
                    default: r_jerk  <= w_rate[31:0];
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_STEP_TIME:  prdata = {1'b0, r_step_time};
            REG_MAX_SPEED:  prdata = {1'b0, r_max_speed};
            REG_STEER_LIM:  prdata = {1'b0, r_steer_limit};
            REG_WHEEL_BASE: prdata = {1'b0, r_wheel_base};
            REG_ACCEL_MIN:  prdata = r_accel_min;
            REG_ACCEL_MAX:  prdata = {1'b0, r_accel_max};
            REG_RATE_LIM:   prdata = {1'b0, r_rate_limit};
            default:        prdata = {1'b0, r_jerk_limit};
        endcase
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_speed       = r_v;
    assign o_steer_angle = r_phi;
    assign o_accel       = r_acc;
    assign o_steer_rate  = r_omega;
    assign o_jerk_value  = r_jerk;

endmodule
